// ----- design/ll1pt_pkg.sv -----
// shared constants, types and helpers of the ll(1) parse table builder
package ll1pt_pkg;

    localparam int NONTERMINALS_DEF = 16;
    localparam int TERMINALS_DEF    = 32;
    localparam int PRODUCTIONS_DEF  = 32;
    localparam int RHS_SYMBOLS_DEF  = 16;

    localparam int KIND_W = 2;
    localparam int IDX_W  = 5;
    localparam int SYM_W  = KIND_W + IDX_W;
    localparam int CNT_W  = 5;
    localparam int HEAD_W = 4;
    localparam int PROD_W = 5;
    localparam int CELL_W = 7;
    localparam int OUT_W  = 32;

    // cell word: valid, conflict, first production
    localparam int CELL_VALID_BIT    = 6;
    localparam int CELL_CONFLICT_BIT = 5;

    localparam logic [KIND_W-1:0] KIND_TERM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EPS   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic CFG_TERMINAL_COUNT    = 1'b0;
    localparam logic CFG_NONTERMINAL_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] TERMINAL_COUNT_RESET    = 5'd31;
    localparam logic [CNT_W-1:0] NONTERMINAL_COUNT_RESET = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RULE,
        ST_WALK,
        ST_FIRST_UPD,
        ST_BACK,
        ST_MIX,
        ST_COLUMN,
        ST_CELL_WR
    } eng_state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_FOLLOW,
        PH_TABLE
    } phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

    // address width that stays legal for a depth of one
    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ----- design/ll1_parse_table_builder.sv -----
// ll(1) parse table builder: grammar loader, query port and stores
// loads and queries: one item per cycle unless busy; a query result strobes the next cycle
// end of grammar: busy while every cell is cleared, then fixed-point passes over the
// rules for first and then follow sets, each repeated until no set changes, then one
// table pass that fills the columns of every rule
// reset clears the flags; rule and cell stores hold garbage until loaded or cleared
module ll1_parse_table_builder
    import ll1pt_pkg::*;
#(
    parameter int NONTERMINALS = NONTERMINALS_DEF,
    parameter int TERMINALS    = TERMINALS_DEF,
    parameter int PRODUCTIONS  = PRODUCTIONS_DEF,
    parameter int RHS_SYMBOLS  = RHS_SYMBOLS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [HEAD_W-1:0] lhs_nonterminal,
    input  logic [KIND_W-1:0] symbol_kind,
    input  logic [IDX_W-1:0]  symbol_index,
    input  logic              end_of_production,
    input  logic              end_of_grammar,
    input  logic [HEAD_W-1:0] query_row,
    input  logic [IDX_W-1:0]  query_column,
    output logic              result_strobe,
    output logic              cell_valid,
    output logic [PROD_W-1:0] cell_production,
    output logic              cell_conflict,
    output logic [OUT_W-1:0]  first_terminals,
    output logic              first_nullable,
    output logic [OUT_W-1:0]  follow_terminals,
    output logic              grammar_is_ll1,
    output logic              tables_ready,
    output logic              load_overflow
);

    localparam int TW  = TERMINALS;
    localparam int UTW = $clog2(TERMINALS);
    localparam int NW  = $clog2(NONTERMINALS + 1);
    localparam int PCW = $clog2(PRODUCTIONS + 1);
    localparam int PIW = addr_width(PRODUCTIONS);
    localparam int LW  = $clog2(RHS_SYMBOLS + 1);
    localparam int SAW = addr_width(PRODUCTIONS * RHS_SYMBOLS);
    localparam int CAW = addr_width(NONTERMINALS * TERMINALS);

    logic [CNT_W-1:0]  terminal_count_reg, nonterminal_count_reg;
    logic [PCW-1:0]    rule_total_reg, rule_total_next, rt_base;
    logic [LW-1:0]     pos_reg, pos_next, sp_base, len_wd;
    logic              ready_reg, ready_next;
    logic              ovf_reg, ovf_next;
    logic              strobe_reg;
    logic              cell_ok_reg;
    logic [OUT_W-1:0]  first_reg, follow_reg;
    logic              null_reg, verdict_reg, ready_q_reg, ovf_q_reg;

    logic [HEAD_W-1:0] rule_heads [PRODUCTIONS];
    logic [LW-1:0]     rule_lengths [PRODUCTIONS];

    logic              load, query, go, restart;
    logic              head_we, len_we, sym_we;
    logic [SAW-1:0]    sym_waddr, sym_raddr;
    logic [SYM_W-1:0]  sym_rdata;
    logic [PIW-1:0]    rule_sel;
    logic [CAW-1:0]    cell_raddr, eng_cell_raddr, cell_waddr;
    logic              cell_we;
    logic [CELL_W-1:0] cell_wdata, cell_rdata;
    logic [TW-1:0]     q_first, q_follow;
    logic              q_null, eng_verdict, row_ok;
    logic [UTW-1:0]    used_t;
    logic [NW-1:0]     used_n;
    eng_status_t       status;

    assign busy    = status.busy;
    assign load    = start && !busy && !mode;
    assign query   = start && !busy && mode;
    assign go      = load && end_of_grammar;
    assign restart = load && ready_reg;
    assign rt_base = ready_reg ? '0 : rule_total_reg;
    assign sp_base = ready_reg ? '0 : pos_reg;
    assign row_ok  = ready_reg && (int'(query_row) < int'(used_n));
    assign sym_waddr  = SAW'(int'(rt_base) * RHS_SYMBOLS + int'(sp_base));
    assign cell_raddr = busy ? eng_cell_raddr
                             : CAW'(int'(query_row) * TERMINALS + int'(query_column));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminal_count_reg    <= TERMINAL_COUNT_RESET;
            nonterminal_count_reg <= NONTERMINAL_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_TERMINAL_COUNT)
            begin
                terminal_count_reg <= cfg_data;
            end
            if (cfg_index == CFG_NONTERMINAL_COUNT)
            begin
                nonterminal_count_reg <= cfg_data;
            end
        end
    end

    // a load after ready starts a new grammar
    always_comb
    begin
        rule_total_next = rule_total_reg;
        pos_next        = pos_reg;
        ready_next      = ready_reg;
        ovf_next        = ovf_reg;
        head_we         = 1'b0;
        len_we          = 1'b0;
        sym_we          = 1'b0;
        len_wd          = sp_base;
        if (load)
        begin
            ready_next      = 1'b0;
            rule_total_next = rt_base;
            pos_next        = sp_base;
            ovf_next        = ready_reg ? 1'b0 : ovf_reg;
            if (int'(rt_base) >= PRODUCTIONS)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                head_we = (sp_base == '0);
                len_we  = 1'b1;
                if (int'(sp_base) < RHS_SYMBOLS)
                begin
                    sym_we   = 1'b1;
                    len_wd   = sp_base + LW'(1);
                    pos_next = sp_base + LW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            if (end_of_production || end_of_grammar)
            begin
                if (int'(rt_base) < PRODUCTIONS)
                begin
                    rule_total_next = rt_base + PCW'(1);
                end
                pos_next = '0;
            end
        end
        if (status.done)
        begin
            ready_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_total_reg <= '0;
            pos_reg        <= '0;
            ready_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            rule_total_reg <= rule_total_next;
            pos_reg        <= pos_next;
            ready_reg      <= ready_next;
            ovf_reg        <= ovf_next;
            strobe_reg     <= query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            rule_heads[rt_base[PIW-1:0]] <= lhs_nonterminal;
        end
        if (len_we)
        begin
            rule_lengths[rt_base[PIW-1:0]] <= len_wd;
        end
        if (query)
        begin
            cell_ok_reg <= row_ok && (int'(query_column) <= int'(used_t));
            first_reg   <= row_ok ? OUT_W'(q_first) : '0;
            null_reg    <= row_ok && q_null;
            follow_reg  <= row_ok ? OUT_W'(q_follow) : '0;
            verdict_reg <= eng_verdict;
            ready_q_reg <= ready_reg;
            ovf_q_reg   <= ovf_reg;
        end
    end

    ll1pt_ram #(
        .WIDTH (SYM_W),
        .DEPTH (PRODUCTIONS * RHS_SYMBOLS)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata ({symbol_kind, symbol_index}),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    ll1pt_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NONTERMINALS * TERMINALS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    ll1pt_engine #(
        .NONTERMINALS (NONTERMINALS),
        .TERMINALS    (TERMINALS),
        .PRODUCTIONS  (PRODUCTIONS),
        .RHS_SYMBOLS  (RHS_SYMBOLS)
    ) u_engine (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .go                    (go),
        .restart               (restart),
        .cfg_terminal_count    (terminal_count_reg),
        .cfg_nonterminal_count (nonterminal_count_reg),
        .rule_total            (rule_total_reg),
        .rule_head             (rule_heads[rule_sel]),
        .rule_len              (rule_lengths[rule_sel]),
        .rule_sel              (rule_sel),
        .sym_raddr             (sym_raddr),
        .sym_rdata             (sym_rdata),
        .cell_raddr            (eng_cell_raddr),
        .cell_we               (cell_we),
        .cell_waddr            (cell_waddr),
        .cell_wdata            (cell_wdata),
        .cell_rdata            (cell_rdata),
        .q_row                 (query_row),
        .q_first               (q_first),
        .q_null                (q_null),
        .q_follow              (q_follow),
        .used_t                (used_t),
        .used_n                (used_n),
        .verdict               (eng_verdict),
        .status                (status)
    );

    assign result_strobe    = strobe_reg;
    assign cell_valid       = cell_ok_reg && cell_rdata[CELL_VALID_BIT];
    assign cell_conflict    = cell_ok_reg && cell_rdata[CELL_CONFLICT_BIT];
    assign cell_production  = cell_ok_reg ? cell_rdata[PROD_W-1:0] : '0;
    assign first_terminals  = first_reg;
    assign first_nullable   = null_reg;
    assign follow_terminals = follow_reg;
    assign grammar_is_ll1   = verdict_reg;
    assign tables_ready     = ready_q_reg;
    assign load_overflow    = ovf_q_reg;

endmodule

// ----- design/ll1pt_ram.sv -----
// generic single write, single read ram with registered read data
module ll1pt_ram
    import ll1pt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [addr_width(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic [addr_width(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/ll1pt_step.sv -----
// one symbol step of a first walk or of a backward follow trailer
module ll1pt_step
    import ll1pt_pkg::*;
#(
    parameter int TW  = 32,
    parameter int UTW = 5,
    parameter int NW  = 5
)
(
    input  logic             forward,
    input  logic [SYM_W-1:0] sym,
    input  logic [TW-1:0]    acc,
    input  logic [TW-1:0]    nt_first,
    input  logic             nt_null,
    input  logic [UTW-1:0]   used_t,
    input  logic [NW-1:0]    used_n,
    output logic [TW-1:0]    result,
    output logic             stop,
    output logic             nt_hit
);

    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic              term_hit;
    logic [TW-1:0]     term_bit;

    assign kind     = sym[SYM_W-1:IDX_W];
    assign idx      = sym[IDX_W-1:0];
    assign term_hit = (kind == KIND_TERM) && (int'(idx) <= int'(used_t));
    assign nt_hit   = (kind == KIND_NT) && (int'(idx) < int'(used_n));
    assign term_bit = TW'(1) << idx;

    // anything else is transparent and derives the empty string
    always_comb
    begin
        result = acc;
        stop   = 1'b0;
        if (term_hit)
        begin
            result = forward ? (acc | term_bit) : term_bit;
            stop   = 1'b1;
        end
        else if (nt_hit)
        begin
            result = forward ? (acc | nt_first) : (nt_first | (nt_null ? acc : '0));
            stop   = !nt_null;
        end
    end

endmodule

// ----- design/ll1pt_engine.sv -----
// sequencer for first/follow fixed points and table build, with the set stores
module ll1pt_engine
    import ll1pt_pkg::*;
#(
    parameter int NONTERMINALS = NONTERMINALS_DEF,
    parameter int TERMINALS    = TERMINALS_DEF,
    parameter int PRODUCTIONS  = PRODUCTIONS_DEF,
    parameter int RHS_SYMBOLS  = RHS_SYMBOLS_DEF,
    localparam int TW  = TERMINALS,
    localparam int UTW = $clog2(TERMINALS),
    localparam int NW  = $clog2(NONTERMINALS + 1),
    localparam int NIW = addr_width(NONTERMINALS),
    localparam int PCW = $clog2(PRODUCTIONS + 1),
    localparam int PIW = addr_width(PRODUCTIONS),
    localparam int LW  = $clog2(RHS_SYMBOLS + 1),
    localparam int SAW = addr_width(PRODUCTIONS * RHS_SYMBOLS),
    localparam int CAW = addr_width(NONTERMINALS * TERMINALS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              restart,
    input  logic [CNT_W-1:0]  cfg_terminal_count,
    input  logic [CNT_W-1:0]  cfg_nonterminal_count,
    input  logic [PCW-1:0]    rule_total,
    input  logic [HEAD_W-1:0] rule_head,
    input  logic [LW-1:0]     rule_len,
    output logic [PIW-1:0]    rule_sel,
    output logic [SAW-1:0]    sym_raddr,
    input  logic [SYM_W-1:0]  sym_rdata,
    output logic [CAW-1:0]    cell_raddr,
    output logic              cell_we,
    output logic [CAW-1:0]    cell_waddr,
    output logic [CELL_W-1:0] cell_wdata,
    input  logic [CELL_W-1:0] cell_rdata,
    input  logic [HEAD_W-1:0] q_row,
    output logic [TW-1:0]     q_first,
    output logic              q_null,
    output logic [TW-1:0]     q_follow,
    output logic [UTW-1:0]    used_t,
    output logic [NW-1:0]     used_n,
    output logic              verdict,
    output eng_status_t       status
);

    localparam int CELLS = NONTERMINALS * TERMINALS;

    eng_state_t     state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [PCW-1:0] p_reg, p_next;
    logic [LW-1:0]  j_reg, j_next;
    logic [UTW:0]   c_reg, c_next;
    logic [TW-1:0]  acc_reg, acc_next;
    logic           nl_reg, nl_next;
    logic           changed_reg, changed_next;
    logic [CAW-1:0] clr_reg, clr_next;
    logic           verdict_reg, verdict_next;
    logic [UTW-1:0] used_t_reg, used_t_next;
    logic [NW-1:0]  used_n_reg, used_n_next;

    logic [TW-1:0]  first_mem [NONTERMINALS];
    logic           null_mem [NONTERMINALS];
    logic [TW-1:0]  follow_mem [NONTERMINALS];

    logic [NIW-1:0] first_ra, follow_ra, h_idx, b_idx;
    logic [TW-1:0]  first_rd, follow_rd;
    logic           null_rd;
    logic           first_we, follow_we, clear_all;
    logic [TW-1:0]  first_wd, follow_wd;
    logic           null_wd;
    logic [UTW-1:0] tcl;
    logic [NW-1:0]  ncl;
    logic [TW-1:0]  step_res;
    logic           step_stop, step_nt, step_fwd;
    logic [CAW-1:0] col_addr;

    function automatic logic [SAW-1:0] sym_addr(input logic [PCW-1:0] p, input int j);
        return SAW'(int'(p) * RHS_SYMBOLS + j);
    endfunction

    assign h_idx     = NIW'(rule_head);
    assign b_idx     = NIW'(sym_rdata[IDX_W-1:0]);
    assign rule_sel  = p_reg[PIW-1:0];
    assign first_rd  = first_mem[first_ra];
    assign null_rd   = null_mem[first_ra];
    assign follow_rd = follow_mem[follow_ra];
    assign q_first   = first_rd;
    assign q_null    = null_rd;
    assign q_follow  = follow_rd;
    assign used_t    = used_t_reg;
    assign used_n    = used_n_reg;
    assign verdict   = verdict_reg;
    assign col_addr  = CAW'(int'(h_idx) * TERMINALS + int'(c_reg));
    assign step_fwd  = (state_reg != ST_BACK);

    // register values clamped to the usable range
    always_comb
    begin
        if (cfg_terminal_count == '0)
        begin
            tcl = UTW'(1);
        end
        else if (int'(cfg_terminal_count) > TERMINALS - 1)
        begin
            tcl = UTW'(TERMINALS - 1);
        end
        else
        begin
            tcl = UTW'(cfg_terminal_count);
        end
        if (cfg_nonterminal_count == '0)
        begin
            ncl = NW'(1);
        end
        else if (int'(cfg_nonterminal_count) > NONTERMINALS)
        begin
            ncl = NW'(NONTERMINALS);
        end
        else
        begin
            ncl = NW'(cfg_nonterminal_count);
        end
    end

    ll1pt_step #(
        .TW  (TW),
        .UTW (UTW),
        .NW  (NW)
    ) u_step (
        .forward  (step_fwd),
        .sym      (sym_rdata),
        .acc      (acc_reg),
        .nt_first (first_rd),
        .nt_null  (null_rd),
        .used_t   (used_t_reg),
        .used_n   (used_n_reg),
        .result   (step_res),
        .stop     (step_stop),
        .nt_hit   (step_nt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FIRST;
            p_reg       <= '0;
            j_reg       <= '0;
            c_reg       <= '0;
            nl_reg      <= 1'b0;
            changed_reg <= 1'b0;
            clr_reg     <= '0;
            verdict_reg <= 1'b1;
            used_t_reg  <= UTW'(1);
            used_n_reg  <= NW'(1);
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            p_reg       <= p_next;
            j_reg       <= j_next;
            c_reg       <= c_next;
            nl_reg      <= nl_next;
            changed_reg <= changed_next;
            clr_reg     <= clr_next;
            verdict_reg <= verdict_next;
            used_t_reg  <= used_t_next;
            used_n_reg  <= used_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (clear_all)
        begin
            for (int i = 0; i < NONTERMINALS; i++)
            begin
                first_mem[i]  <= '0;
                null_mem[i]   <= 1'b0;
                // end marker goes into follow of the start symbol
                follow_mem[i] <= (i == 0) ? (TW'(1) << tcl) : '0;
            end
        end
        else
        begin
            if (first_we)
            begin
                first_mem[first_ra] <= first_wd;
                null_mem[first_ra]  <= null_wd;
            end
            if (follow_we)
            begin
                follow_mem[follow_ra] <= follow_wd;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        p_next       = p_reg;
        j_next       = j_reg;
        c_next       = c_reg;
        acc_next     = acc_reg;
        nl_next      = nl_reg;
        changed_next = changed_reg;
        clr_next     = clr_reg;
        verdict_next = verdict_reg;
        used_t_next  = used_t_reg;
        used_n_next  = used_n_reg;
        sym_raddr    = sym_addr(p_reg, int'(j_reg));
        cell_raddr   = col_addr;
        cell_we      = 1'b0;
        cell_waddr   = col_addr;
        cell_wdata   = '0;
        first_ra     = h_idx;
        follow_ra    = h_idx;
        first_we     = 1'b0;
        first_wd     = first_rd | acc_reg;
        null_wd      = null_rd | nl_reg;
        follow_we    = 1'b0;
        follow_wd    = follow_rd | acc_reg;
        clear_all    = 1'b0;
        status.busy  = (state_reg != ST_IDLE);
        status.done  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                first_ra  = NIW'(q_row);
                follow_ra = NIW'(q_row);
                if (restart)
                begin
                    verdict_next = 1'b1;
                end
                if (go)
                begin
                    clear_all    = 1'b1;
                    used_t_next  = tcl;
                    used_n_next  = ncl;
                    verdict_next = 1'b1;
                    phase_next   = PH_FIRST;
                    p_next       = '0;
                    changed_next = 1'b0;
                    clr_next     = '0;
                    state_next   = ST_CLEAR;
                end
            end

            ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg;
                if (int'(clr_reg) == CELLS - 1)
                begin
                    state_next = ST_RULE;
                end
                else
                begin
                    clr_next = clr_reg + CAW'(1);
                end
            end

            ST_RULE:
            begin
                if (p_reg >= rule_total)
                begin
                    p_next       = '0;
                    changed_next = 1'b0;
                    if (phase_reg == PH_FIRST && !changed_reg)
                    begin
                        phase_next = PH_FOLLOW;
                    end
                    else if (phase_reg == PH_FOLLOW && !changed_reg)
                    begin
                        phase_next = PH_TABLE;
                    end
                    else if (phase_reg == PH_TABLE)
                    begin
                        status.done = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (int'(rule_head) >= int'(used_n_reg))
                begin
                    p_next = p_reg + PCW'(1);
                end
                else if (phase_reg == PH_FOLLOW)
                begin
                    // walk backward carrying the trailer set
                    j_next     = rule_len - LW'(1);
                    sym_raddr  = sym_addr(p_reg, int'(rule_len) - 1);
                    acc_next   = follow_rd;
                    state_next = ST_BACK;
                end
                else
                begin
                    j_next     = '0;
                    sym_raddr  = sym_addr(p_reg, 0);
                    acc_next   = '0;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                first_ra = b_idx;
                acc_next = step_res;
                if (step_stop || (j_reg + LW'(1) == rule_len))
                begin
                    nl_next    = !step_stop;
                    state_next = (phase_reg == PH_FIRST) ? ST_FIRST_UPD : ST_MIX;
                end
                else
                begin
                    j_next    = j_reg + LW'(1);
                    sym_raddr = sym_addr(p_reg, int'(j_reg) + 1);
                end
            end

            ST_FIRST_UPD:
            begin
                first_we = 1'b1;
                if ((first_wd != first_rd) || (nl_reg && !null_rd))
                begin
                    changed_next = 1'b1;
                end
                p_next     = p_reg + PCW'(1);
                state_next = ST_RULE;
            end

            ST_BACK:
            begin
                first_ra  = b_idx;
                follow_ra = b_idx;
                acc_next  = step_res;
                if (step_nt)
                begin
                    follow_we = 1'b1;
                    if (follow_wd != follow_rd)
                    begin
                        changed_next = 1'b1;
                    end
                end
                if (j_reg == '0)
                begin
                    p_next     = p_reg + PCW'(1);
                    state_next = ST_RULE;
                end
                else
                begin
                    j_next    = j_reg - LW'(1);
                    sym_raddr = sym_addr(p_reg, int'(j_reg) - 1);
                end
            end

            ST_MIX:
            begin
                if (nl_reg)
                begin
                    acc_next = acc_reg | follow_rd;
                end
                c_next     = '0;
                state_next = ST_COLUMN;
            end

            ST_COLUMN:
            begin
                if (int'(c_reg) > int'(used_t_reg))
                begin
                    p_next     = p_reg + PCW'(1);
                    state_next = ST_RULE;
                end
                else if (acc_reg[c_reg[UTW-1:0]])
                begin
                    state_next = ST_CELL_WR;
                end
                else
                begin
                    c_next = c_reg + (UTW+1)'(1);
                end
            end

            ST_CELL_WR:
            begin
                cell_we = 1'b1;
                if (cell_rdata[CELL_VALID_BIT])
                begin
                    cell_wdata                    = cell_rdata;
                    cell_wdata[CELL_CONFLICT_BIT] = 1'b1;
                    verdict_next                  = 1'b0;
                end
                else
                begin
                    cell_wdata                    = '0;
                    cell_wdata[CELL_VALID_BIT]    = 1'b1;
                    cell_wdata[PROD_W-1:0]        = PROD_W'(p_reg);
                end
                c_next     = c_reg + (UTW+1)'(1);
                state_next = ST_COLUMN;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- tb/ll1_table_checker.sv -----
// checker for the ll(1) parse table builder: predicts query results and compares them
module ll1_table_checker
    import ll1pt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              start,
    input  logic              busy,
    input  logic              mode,
    input  logic [HEAD_W-1:0] lhs_nonterminal,
    input  logic [KIND_W-1:0] symbol_kind,
    input  logic [IDX_W-1:0]  symbol_index,
    input  logic              end_of_production,
    input  logic              end_of_grammar,
    input  logic [HEAD_W-1:0] query_row,
    input  logic [IDX_W-1:0]  query_column,
    input  logic              result_strobe,
    input  logic              cell_valid,
    input  logic [PROD_W-1:0] cell_production,
    input  logic              cell_conflict,
    input  logic [OUT_W-1:0]  first_terminals,
    input  logic              first_nullable,
    input  logic [OUT_W-1:0]  follow_terminals,
    input  logic              grammar_is_ll1,
    input  logic              tables_ready,
    input  logic              load_overflow,
    output int                error_count,
    output int                pending_cells
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT_MAX  = NONTERMINALS_DEF;
    localparam int T_MAX   = TERMINALS_DEF;
    localparam int P_MAX   = PRODUCTIONS_DEF;
    localparam int RHS_MAX = RHS_SYMBOLS_DEF;

    typedef struct {
        logic              valid;
        logic [PROD_W-1:0] prod;
        logic              conflict;
        logic [OUT_W-1:0]  first_set;
        logic              nullable;
        logic [OUT_W-1:0]  follow_set;
        logic              is_ll1;
        logic              ready;
        logic              overflow;
    } cell_answer_t;

    cell_answer_t answer_q[$];

    logic [SYM_W-1:0]  rhs_sym [P_MAX*RHS_MAX];
    logic [HEAD_W-1:0] rule_head [P_MAX];
    int                rule_len [P_MAX];
    int                rules_loaded;
    int                sym_pos;
    logic [OUT_W-1:0]  first_set [NT_MAX];
    logic              first_nul [NT_MAX];
    logic [OUT_W-1:0]  follow_set [NT_MAX];
    logic [CELL_W-1:0] table_cell [NT_MAX*T_MAX];
    logic              is_ll1, ready, overflow;
    logic [CNT_W-1:0]  term_reg, nonterm_reg;
    int                live_t, live_n;

    assign pending_cells = answer_q.size();

    // first set of a rule suffix; nl reports whether the suffix can vanish
    function automatic logic [OUT_W-1:0] suffix_first(input int p, input int from,
                                                      output logic nl);
        logic [OUT_W-1:0] s;
        logic [KIND_W-1:0] k;
        int i;
        s = '0;
        for (int j = from; j < rule_len[p] && j < RHS_MAX; j++) begin
            k = rhs_sym[p*RHS_MAX+j][SYM_W-1:IDX_W];
            i = rhs_sym[p*RHS_MAX+j][IDX_W-1:0];
            if (k == KIND_TERM && i <= live_t) begin
                nl = 1'b0;
                return s | (OUT_W'(1) << i);
            end
            if (k == KIND_NT && i < live_n) begin
                s |= first_set[i];
                if (!first_nul[i]) begin
                    nl = 1'b0;
                    return s;
                end
            end
        end
        nl = 1'b1;
        return s;
    endfunction

    function automatic void build_tables();
        logic changed, nl;
        logic [OUT_W-1:0] s;
        int h, b;
        live_t = (term_reg < 1) ? 1 : (term_reg > T_MAX-1) ? T_MAX-1 : term_reg;
        live_n = (nonterm_reg < 1) ? 1 : (nonterm_reg > NT_MAX) ? NT_MAX : nonterm_reg;
        for (int n = 0; n < NT_MAX; n++) begin
            first_set[n] = '0;
            first_nul[n] = 1'b0;
            follow_set[n] = '0;
        end
        for (int c = 0; c < NT_MAX*T_MAX; c++) table_cell[c] = '0;
        do begin
            changed = 1'b0;
            for (int p = 0; p < rules_loaded && p < P_MAX; p++) begin
                h = rule_head[p];
                if (h >= live_n) continue;
                s = suffix_first(p, 0, nl);
                if ((first_set[h] | s) != first_set[h] || (nl && !first_nul[h])) begin
                    first_set[h] |= s;
                    if (nl) first_nul[h] = 1'b1;
                    changed = 1'b1;
                end
            end
        end while (changed);
        follow_set[0] = OUT_W'(1) << live_t;
        do begin
            changed = 1'b0;
            for (int p = 0; p < rules_loaded && p < P_MAX; p++) begin
                h = rule_head[p];
                if (h >= live_n) continue;
                for (int j = 0; j < rule_len[p] && j < RHS_MAX; j++) begin
                    b = rhs_sym[p*RHS_MAX+j][IDX_W-1:0];
                    if (rhs_sym[p*RHS_MAX+j][SYM_W-1:IDX_W] != KIND_NT || b >= live_n)
                        continue;
                    s = suffix_first(p, j+1, nl);
                    if (nl) s |= follow_set[h];
                    if ((follow_set[b] | s) != follow_set[b]) begin
                        follow_set[b] |= s;
                        changed = 1'b1;
                    end
                end
            end
        end while (changed);
        is_ll1 = 1'b1;
        for (int p = 0; p < rules_loaded && p < P_MAX; p++) begin
            h = rule_head[p];
            if (h >= live_n) continue;
            s = suffix_first(p, 0, nl);
            if (nl) s |= follow_set[h];
            for (int c = 0; c <= live_t; c++) begin
                if (!s[c]) continue;
                if (!table_cell[h*T_MAX+c][CELL_VALID_BIT]) begin
                    table_cell[h*T_MAX+c] = '0;
                    table_cell[h*T_MAX+c][CELL_VALID_BIT] = 1'b1;
                    table_cell[h*T_MAX+c][PROD_W-1:0] = PROD_W'(p);
                end else begin
                    table_cell[h*T_MAX+c][CELL_CONFLICT_BIT] = 1'b1;
                    is_ll1 = 1'b0;
                end
            end
        end
        ready = 1'b1;
    endfunction

    function automatic void load_symbol();
        if (ready) begin
            rules_loaded = 0;
            sym_pos = 0;
            overflow = 1'b0;
            ready = 1'b0;
            is_ll1 = 1'b1;
        end
        if (rules_loaded >= P_MAX) begin
            overflow = 1'b1;
        end else begin
            if (sym_pos == 0) rule_head[rules_loaded] = lhs_nonterminal;
            if (sym_pos < RHS_MAX) begin
                rhs_sym[rules_loaded*RHS_MAX+sym_pos] = {symbol_kind, symbol_index};
                sym_pos++;
            end else begin
                overflow = 1'b1;
            end
            rule_len[rules_loaded] = sym_pos;
        end
        if (end_of_production || end_of_grammar) begin
            if (rules_loaded < P_MAX) rules_loaded++;
            sym_pos = 0;
        end
        if (end_of_grammar) build_tables();
    endfunction

    function automatic cell_answer_t look_up();
        cell_answer_t a;
        logic [CELL_W-1:0] c;
        c = '0;
        a.first_set = '0;
        a.nullable = 1'b0;
        a.follow_set = '0;
        if (ready && query_row < live_n) begin
            a.first_set = first_set[query_row];
            a.nullable = first_nul[query_row];
            a.follow_set = follow_set[query_row];
            if (query_column <= live_t) c = table_cell[query_row*T_MAX+query_column];
        end
        a.valid = c[CELL_VALID_BIT];
        a.prod = c[PROD_W-1:0];
        a.conflict = c[CELL_CONFLICT_BIT];
        a.is_ll1 = is_ll1;
        a.ready = ready;
        a.overflow = overflow;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        cell_answer_t e;
        if (!rst_n) begin
            answer_q.delete();
            error_count <= 0;
            rules_loaded = 0;
            sym_pos = 0;
            is_ll1 = 1'b1;
            ready = 1'b0;
            overflow = 1'b0;
            term_reg = TERMINAL_COUNT_RESET;
            nonterm_reg = NONTERMINAL_COUNT_RESET;
            live_t = 1;
            live_n = 1;
        end else begin
            if (cfg_write) begin
                if (cfg_index == CFG_TERMINAL_COUNT) term_reg = cfg_data;
                else nonterm_reg = cfg_data;
            end
            if (result_strobe) begin
                if (answer_q.size() == 0) begin
                    $error("result with no query outstanding");
                    error_count <= error_count + 1;
                end else begin
                    e = answer_q.pop_front();
                    if (cell_valid !== e.valid ||
                        (e.valid && cell_production !== e.prod) ||
                        (!e.valid && cell_production !== '0) ||
                        cell_conflict !== e.conflict || first_terminals !== e.first_set ||
                        first_nullable !== e.nullable || follow_terminals !== e.follow_set ||
                        grammar_is_ll1 !== e.is_ll1 || tables_ready !== e.ready ||
                        load_overflow !== e.overflow)
                        error_count <= error_count + 1;
                    if (cell_valid !== e.valid)
                        $error("cell_valid exp %0b got %0b", e.valid, cell_valid);
                    if (cell_production !== e.prod)
                        $error("cell_production exp %0d got %0d", e.prod, cell_production);
                    if (cell_conflict !== e.conflict)
                        $error("cell_conflict exp %0b got %0b", e.conflict, cell_conflict);
                    if (first_terminals !== e.first_set)
                        $error("first_terminals exp %h got %h", e.first_set, first_terminals);
                    if (first_nullable !== e.nullable)
                        $error("first_nullable exp %0b got %0b", e.nullable, first_nullable);
                    if (follow_terminals !== e.follow_set)
                        $error("follow_terminals exp %h got %h", e.follow_set,
                               follow_terminals);
                    if (grammar_is_ll1 !== e.is_ll1)
                        $error("grammar_is_ll1 exp %0b got %0b", e.is_ll1, grammar_is_ll1);
                    if (tables_ready !== e.ready)
                        $error("tables_ready exp %0b got %0b", e.ready, tables_ready);
                    if (load_overflow !== e.overflow)
                        $error("load_overflow exp %0b got %0b", e.overflow, load_overflow);
                end
            end
            if (start && !busy) begin
                if (mode) answer_q.push_back(look_up());
                else load_symbol();
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// testbench top of the ll(1) parse table builder: stimulus, watchdog and verdict
module tb_top;
    import ll1pt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              start = 1'b0;
    logic              busy;
    logic              mode = 1'b0;
    logic [HEAD_W-1:0] lhs_nonterminal = '0;
    logic [KIND_W-1:0] symbol_kind = '0;
    logic [IDX_W-1:0]  symbol_index = '0;
    logic              end_of_production = 1'b0;
    logic              end_of_grammar = 1'b0;
    logic [HEAD_W-1:0] query_row = '0;
    logic [IDX_W-1:0]  query_column = '0;
    logic              result_strobe, cell_valid, cell_conflict, first_nullable;
    logic [PROD_W-1:0] cell_production;
    logic [OUT_W-1:0]  first_terminals, follow_terminals;
    logic              grammar_is_ll1, tables_ready, load_overflow;
    int                error_count, pending_cells;
    int                items_sent = 0;
    int                burst_left = 0;
    int                idle_cycles = 0;
    int                term_now = 31, nonterm_now = 16;

    ll1_parse_table_builder u_top (.*);
    ll1_table_checker u_checker (.*);

    initial forever #1 clk = ~clk;

    always @(posedge clk) begin
        if ((start && !busy) || result_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(input logic m, input int lhs, input int kind, input int idx,
                        input logic eop, input logic eog, input int row, input int col);
        int gap;
        logic free;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        mode <= m;
        lhs_nonterminal <= HEAD_W'(lhs);
        symbol_kind <= KIND_W'(kind);
        symbol_index <= IDX_W'(idx);
        end_of_production <= eop;
        end_of_grammar <= eog;
        query_row <= HEAD_W'(row);
        query_column <= IDX_W'(col);
        start <= 1'b1;
        do begin
            @(negedge clk);
            free = !busy;
            @(posedge clk);
        end while (!free);
        items_sent++;
    endtask

    task automatic query(input int row, input int col);
        send(1'b1, $urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 31),
             $urandom_range(0, 1), 1'b0, row, col);
    endtask

    task automatic load(input int lhs, input int kind, input int idx,
                        input logic eop, input logic eog);
        send(1'b0, lhs, kind, idx, eop, eog, $urandom_range(0, 15), $urandom_range(0, 31));
    endtask

    // wait for all answers and for the engine to go quiet
    task automatic settle();
        logic b;
        start <= 1'b0;
        while (pending_cells != 0) @(posedge clk);
        do begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
        end while (b);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input int val);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CNT_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_TERMINAL_COUNT) term_now = (val < 1) ? 1 : val;
        else nonterm_now = (val < 1) ? 1 : (val > 16) ? 16 : val;
    endtask

    function automatic int pick_t();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(0, term_now);
    endfunction

    function automatic int pick_n();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(0, nonterm_now - 1);
    endfunction

    task automatic random_grammar();
        int nprod, len, lhs, kind, r;
        nprod = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
        for (int p = 0; p < nprod; p++) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 4);
            lhs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(0, nonterm_now - 1);
            for (int j = 0; j < len; j++) begin
                r = $urandom_range(0, 99);
                kind = (r < 45) ? KIND_TERM : (r < 85) ? KIND_NT :
                       (r < 95) ? KIND_EPS : KIND_SPARE;
                // noise: a query in the middle of loading
                if ($urandom_range(0, 29) == 0) query(pick_n(), pick_t());
                load(lhs, kind, (kind == KIND_NT) ? pick_n() : pick_t(), j == len - 1,
                     (p == nprod - 1 && j == len - 1) ||
                     ($urandom_range(0, 199) == 0));
            end
        end
    endtask

    initial begin
        int nq, r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // before any grammar: all-zero cells, defaults still in place
        query(0, 0);
        query(15, 31);
        set_reg(CFG_TERMINAL_COUNT, 2);
        set_reg(CFG_NONTERMINAL_COUNT, 3);
        // expression-like grammar with an epsilon rule and one conflicting pair
        load(0, KIND_NT, 2, 1'b0, 1'b0);
        load(0, KIND_NT, 1, 1'b1, 1'b0);
        load(1, KIND_TERM, 0, 1'b0, 1'b0);
        load(1, KIND_NT, 2, 1'b0, 1'b0);
        load(1, KIND_NT, 1, 1'b1, 1'b0);
        load(1, KIND_EPS, 0, 1'b1, 1'b0);
        load(2, KIND_TERM, 1, 1'b1, 1'b0);
        load(2, KIND_TERM, 1, 1'b0, 1'b0);
        load(2, KIND_TERM, 0, 1'b0, 1'b1);
        for (int row = 0; row < 3; row++)
            for (int col = 0; col < 3; col++) query(row, col);
        query(15, 31);
        query(1, 31);
        settle();
        while (items_sent < 1550) begin
            r = $urandom_range(0, 5);
            if (r == 0) begin
                r = $urandom_range(0, 3);
                set_reg(CFG_TERMINAL_COUNT, (r == 0) ? 0 : (r == 1) ? 1 :
                                            (r == 2) ? 31 : $urandom_range(2, 30));
                r = $urandom_range(0, 4);
                set_reg(CFG_NONTERMINAL_COUNT, (r == 0) ? 0 : (r == 1) ? 1 :
                                               (r == 2) ? 16 : (r == 3) ? 31 :
                                               $urandom_range(2, 15));
            end
            random_grammar();
            nq = $urandom_range(8, 25);
            for (int q = 0; q < nq; q++) query(pick_n(), pick_t());
            if ($urandom_range(0, 3) == 0) settle();
        end
        settle();
        repeat (20) @(posedge clk);
        if (error_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
